/* src/abrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrm_pkg: shared constants and types for the adaptive binary rate model
// Count width, log2 result format and the status bundle of the log2 unit.
// ----------------------------------------------------------------------------
package abrm_pkg;

    // width of the zero and total counters
    localparam int COUNT_WIDTH = 16;
    // bits of the log2 integer part (index of the top set bit of a count)
    localparam int EXP_W       = $clog2(COUNT_WIDTH);
    // fraction bits produced by the squaring loop
    localparam int FRAC_BITS   = 16;
    localparam int LOG_W       = EXP_W + FRAC_BITS;
    // mantissa is Q1.30, so 31 bits
    localparam int MANT_W      = 31;
    localparam int SH_W        = $clog2(MANT_W);
    localparam int ITER_W      = $clog2(FRAC_BITS);

    localparam logic [COUNT_WIDTH-1:0] START_ZEROS = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] START_TOTAL = COUNT_WIDTH'(2);
    localparam logic [15:0]            MAX_FREQ_RST = 16'd4096;

    // status of the log2 unit toward its sequencer
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [LOG_W-1:0] value;
    } t_log_rsp;

endpackage

/* src/abrm_log2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrm_log2: iterative fixed-point log2 of a count
// Normalize on start, then square the mantissa once per cycle, one fraction
// bit per square. Result is {exponent, fraction} with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module abrm_log2 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [abrm_pkg::COUNT_WIDTH-1:0] i_x,
    output abrm_pkg::t_log_rsp              o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [abrm_pkg::ITER_W-1:0]     r_cnt;
    logic [abrm_pkg::EXP_W-1:0]      r_exp;
    logic [abrm_pkg::FRAC_BITS-1:0]  r_frac;
    logic [abrm_pkg::MANT_W-1:0]     r_mant;

    logic [abrm_pkg::COUNT_WIDTH-1:0] x_nz;
    logic [abrm_pkg::EXP_W-1:0]       top_idx;
    logic [abrm_pkg::SH_W-1:0]        norm_sh;
    logic [2*abrm_pkg::MANT_W-1:0]    sq_full;
    logic [abrm_pkg::MANT_W:0]        sq;
    logic [abrm_pkg::MANT_W-1:0]      n_mant;

    // zero is taken as one; find the top set bit
    always_comb begin
        x_nz    = (i_x == '0) ? abrm_pkg::COUNT_WIDTH'(1) : i_x;
        top_idx = '0;
        for (int i = 0; i < abrm_pkg::COUNT_WIDTH; i++) begin
            if (x_nz[i]) begin
                top_idx = abrm_pkg::EXP_W'(i);
            end
        end
        norm_sh = abrm_pkg::SH_W'(abrm_pkg::MANT_W - 1) - abrm_pkg::SH_W'(top_idx);
    end

    // one square per cycle; a square at or above 2.0 yields a one bit
    always_comb begin
        sq_full = {{abrm_pkg::MANT_W{1'b0}}, r_mant} * {{abrm_pkg::MANT_W{1'b0}}, r_mant};
        sq      = sq_full[2*abrm_pkg::MANT_W-1:abrm_pkg::MANT_W-1];
        if (sq[abrm_pkg::MANT_W]) begin
            n_mant = sq[abrm_pkg::MANT_W:1];
        end else begin
            n_mant = sq[abrm_pkg::MANT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == abrm_pkg::ITER_W'(abrm_pkg::FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_exp  <= top_idx;
            r_frac <= '0;
            r_mant <= abrm_pkg::MANT_W'(x_nz) << norm_sh;
        end else if (r_busy) begin
            r_mant <= n_mant;
            r_frac <= {r_frac[abrm_pkg::FRAC_BITS-2:0], sq[abrm_pkg::MANT_W]};
        end
    end

    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_done;
    assign o_rsp.value = {r_exp, r_frac};

    // a result appears only at the end of a run
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("log2 done without a run");

    // a new start never lands on a run in progress
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("log2 restarted while busy");

endmodule

/* src/adaptive_binary_rate_model.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_binary_rate_model: adaptive binary context model with rescaling
// Counts zeros and total bits, halves both at a programmable threshold and
// returns the cost of each symbol, -log2(p), in bits with 10 fraction bits.
// ----------------------------------------------------------------------------
//
//  channel   ports          direction  contents (low bit first)
//  --------  -------------  ---------  ---------------------------------------
//  s (in)    i_s_tvalid/..  in         tuser[0] opcode, tdata[0] bit_value
//  m (out)   o_m_tvalid/..  out        tdata cost_zero, cost_one, zero_count,
//                                      total_count (16 bits each)
//  cfg       i_cfg_we       in         i_cfg_wdata = max_frequency
//
//  Sequence: the single log2 unit runs three times per item (log2 of total,
//    of zeros, of ones), each run a load, one squaring step per fraction bit
//    and a hand-over. Plus accept, count update and output.
//  Reset: synchronous, active low; counts go to 1 and 2, max_frequency 4096.
//  Stalls: the result sits in an output register; a new item is taken while
//    it waits, and the sequencer holds at the end until the register frees.
//  A reset item (opcode 1) runs the same path and yields 1.0 for both costs.
// ----------------------------------------------------------------------------
module adaptive_binary_rate_model (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] bit_value, [7:1] zero
    input  logic [0:0]  i_s_tuser,   // [0] opcode
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [15:0] cost_zero, [31:16] cost_one,
                                     // [47:32] zero_count, [63:48] total_count
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int CW = abrm_pkg::COUNT_WIDTH;
    localparam int LW = abrm_pkg::LOG_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_GO   = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // which log2 is being taken
    localparam logic [1:0] SEL_TOTAL = 2'd0;
    localparam logic [1:0] SEL_ZEROS = 2'd1;
    localparam logic [1:0] SEL_ONES  = 2'd2;

    localparam logic [31:0] CNT_MAX = 32'((64'd1 << CW) - 64'd1);

    logic [2:0]    r_state;
    logic [1:0]    r_sel;
    logic          r_op;
    logic          r_bit;
    logic [15:0]   r_max_freq;
    logic [CW-1:0] r_zeros;
    logic [CW-1:0] r_all;
    logic [LW-1:0] r_lt;
    logic [LW-1:0] r_lz;
    logic [LW-1:0] r_lo;
    logic          r_out_valid;
    logic [63:0]   r_out_data;

    logic [CW-1:0] n_zeros;
    logic [CW-1:0] n_all;
    logic [31:0]   limit;
    logic [CW-1:0] log_x;
    logic          log_start;
    logic          s_accept;
    logic          out_free;
    logic [LW-1:0] d_zero;
    logic [LW-1:0] d_one;
    logic [15:0]   cost_zero;
    logic [15:0]   cost_one;
    abrm_pkg::t_log_rsp log_rsp;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign log_start  = (r_state == S_GO);

    // count update: a reset item loads the start counts; otherwise bump, halve at
    // the threshold, then repair so that 1 <= zeros < total holds
    always_comb begin
        limit = (32'(r_max_freq) > CNT_MAX) ? CNT_MAX : 32'(r_max_freq);
        if (r_op) begin
            n_zeros = abrm_pkg::START_ZEROS;
            n_all   = abrm_pkg::START_TOTAL;
        end else begin
            n_zeros = r_bit ? r_zeros : r_zeros + 1'b1;
            n_all   = r_all + 1'b1;
            if (32'(n_all) >= limit) begin
                n_zeros = n_zeros >> 1;
                n_all   = n_all >> 1;
                if (n_zeros == '0) begin
                    n_zeros = CW'(1);
                    n_all   = n_all + 1'b1;
                end
                if (n_zeros >= n_all) begin
                    n_all = n_zeros + 1'b1;
                end
            end
        end
    end

    // operand of the shared log2 unit
    always_comb begin
        case (r_sel)
            SEL_TOTAL: log_x = r_all;
            SEL_ZEROS: log_x = r_zeros;
            SEL_ONES:  log_x = r_all - r_zeros;
            default:   log_x = r_all;
        endcase
    end

    abrm_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_rsp   (log_rsp)
    );

    // cost = max(log2 total - log2 count, 0), rounded to 10 fraction bits
    always_comb begin
        d_zero    = (r_lt > r_lz) ? r_lt - r_lz : '0;
        d_one     = (r_lt > r_lo) ? r_lt - r_lo : '0;
        cost_zero = 16'(({1'b0, d_zero} + (LW+1)'(32)) >> 6);
        cost_one  = 16'(({1'b0, d_one}  + (LW+1)'(32)) >> 6);
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_TOTAL;
            r_max_freq  <= abrm_pkg::MAX_FREQ_RST;
            r_zeros     <= abrm_pkg::START_ZEROS;
            r_all       <= abrm_pkg::START_TOTAL;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_freq <= i_cfg_wdata;
            end
            // raise on a new result, drop once the sink takes it
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_zeros <= n_zeros;
                    r_all   <= n_all;
                    r_sel   <= SEL_TOTAL;
                    r_state <= S_GO;
                end
                S_GO: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (log_rsp.done) begin
                        if (r_sel == SEL_ONES) begin
                            r_state <= S_FIN;
                        end else begin
                            r_sel   <= r_sel + 1'b1;
                            r_state <= S_GO;
                        end
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op  <= i_s_tuser[0];
            r_bit <= i_s_tdata[0];
        end
        if (r_state == S_WAIT && log_rsp.done) begin
            case (r_sel)
                SEL_TOTAL: r_lt <= log_rsp.value;
                SEL_ZEROS: r_lz <= log_rsp.value;
                SEL_ONES:  r_lo <= log_rsp.value;
                default:   r_lt <= log_rsp.value;
            endcase
        end
        if (r_state == S_FIN && out_free) begin
            r_out_data <= {16'(r_all), 16'(r_zeros), cost_one, cost_zero};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // an accepted item always goes to the count update next
    a_accept_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_UPD))
        else $error("accepted item did not reach count update");

    // counts stay ordered: 1 <= zeros < total
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_zeros != '0) && (r_zeros < r_all))
        else $error("count invariant broken");

    // the log2 unit is never started while running
    a_log_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        log_start |-> !log_rsp.busy)
        else $error("log2 unit started while busy");

    // a result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> r_out_valid)
        else $error("result lost at output");

endmodule
